>>> rtl/vvfm_pkg.sv
// Shared types and constants for the voxel visible-face mask block.
// Used by the face evaluation stage and the top level under rtl/; depends on nothing.
`default_nettype none

package vvfm_pkg;

  // Grid edge supported by storage, and the register's reset value
  localparam int GRID_DEF = 16;
  localparam int GRID_SIZE_W = 5;
  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 5'd16;

  // Coordinates compared against the grid size travel at this width
  localparam int COORD_W = 6;

  // Vertex counter
  localparam int CNT_W = 17;
  localparam int VERTS_PER_FACE = 4;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [3:0]  cell_x;
    logic [3:0]  cell_y;
    logic [3:0]  cell_z;
    logic [15:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic             solid;
    logic [5:0]       face_mask;
    logic [2:0]       face_count;
    logic [CNT_W-1:0] first_vertex;
  } out_item_t;

  // Command held alongside the row reads while they are in flight
  typedef struct packed {
    logic       valid;
    logic       operation;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] cell_z;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/vvfm_row_store.sv
// One copy of the occupancy row memory: one write port, one registered read port.
// Depends on nothing; instantiated once per row read (the voxel's row and each neighbor row) by the top level.
`default_nettype none

module vvfm_row_store #(
  parameter int GRID = 16
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(GRID*GRID)-1:0]    wr_addr,
  input  wire logic [GRID-1:0]                 wr_data,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(GRID*GRID)-1:0]    rd_addr,
  output logic      [GRID-1:0]                 rd_data_r
);

  localparam int DEPTH = GRID * GRID;

  logic [GRID-1:0] mem [DEPTH];

  // Write one row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one row, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/vvfm_face_eval.sv
// Face evaluation stage: command register, neighbor tests, vertex counter, result register.
// Depends on vvfm_pkg; takes the five rows read by the top level's row stores.
`default_nettype none

module vvfm_face_eval #(
  parameter int GRID = vvfm_pkg::GRID_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire vvfm_pkg::cmd_t                       cmd,
  input  wire logic [vvfm_pkg::GRID_SIZE_W-1:0]     grid_size,
  input  wire logic [GRID-1:0]                      row_c,
  input  wire logic [GRID-1:0]                      row_yp,
  input  wire logic [GRID-1:0]                      row_ym,
  input  wire logic [GRID-1:0]                      row_zp,
  input  wire logic [GRID-1:0]                      row_zm,
  output logic                                      out_valid_r,
  output vvfm_pkg::out_item_t                       out_item_r
);

  import vvfm_pkg::*;

  cmd_t             cmd_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [COORD_W-1:0] n, x, y, z, xp, xm, grid6;
  logic             c_solid;
  logic [5:0]       mask;
  logic [2:0]       count;
  out_item_t        out_nxt;

  // Bit of a row at a coordinate
  function automatic logic bit_at(input logic [GRID-1:0] row, input logic [COORD_W-1:0] idx);
    logic [GRID-1:0] sh;
    sh = row >> idx;
    return sh[0];
  endfunction

  // Hold the command while its rows are read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r.valid <= 1'b0;
    end else begin
      cmd_r.valid <= cmd.valid;
    end
    cmd_r.operation <= cmd.operation;
    cmd_r.cell_x    <= cmd.cell_x;
    cmd_r.cell_y    <= cmd.cell_y;
    cmd_r.cell_z    <= cmd.cell_z;
  end

  // Clamp the grid size and test the voxel and its six neighbors
  always_comb begin
    grid6 = COORD_W'(GRID);
    n  = (COORD_W'(grid_size) > grid6) ? grid6 : COORD_W'(grid_size);
    x  = COORD_W'(cmd_r.cell_x);
    y  = COORD_W'(cmd_r.cell_y);
    z  = COORD_W'(cmd_r.cell_z);
    xp = x + COORD_W'(1);
    xm = x - COORD_W'(1);
    c_solid = (x < n) & (y < n) & (z < n) & bit_at(row_c, x);
    mask[0] = c_solid & ~(((y + COORD_W'(1)) < n) & bit_at(row_yp, x));
    mask[1] = c_solid & ~((y != '0) & bit_at(row_ym, x));
    mask[2] = c_solid & ~((xp < n) & bit_at(row_c, xp));
    mask[3] = c_solid & ~((x != '0) & bit_at(row_c, xm));
    mask[4] = c_solid & ~(((z + COORD_W'(1)) < n) & bit_at(row_zp, x));
    mask[5] = c_solid & ~((z != '0) & bit_at(row_zm, x));
    count = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2])
          + 3'(mask[3]) + 3'(mask[4]) + 3'(mask[5]);
  end

  // Build the result and the next counter value
  always_comb begin
    cnt_nxt = cnt_r;
    out_nxt = '0;
    if (cmd_r.valid) begin
      if (cmd_r.operation == OP_LOAD) begin
        cnt_nxt = '0;
      end else begin
        out_nxt.solid        = c_solid;
        out_nxt.face_mask    = mask;
        out_nxt.face_count   = count;
        out_nxt.first_vertex = cnt_r;
        cnt_nxt = cnt_r + CNT_W'(count) * CNT_W'(VERTS_PER_FACE);
      end
    end
  end

  // Advance the counter and register the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd_r.valid;
    end
    out_item_r <= out_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/voxel_visible_face_mask.sv
// Top level of the voxel visible-face mask: grid size register, clearing pass,
// five row store copies and the face evaluation stage. Depends on vvfm_pkg.
//
//   channel  ports                       handshake
//   input    start, busy, in_item        beat taken when start & !busy
//   result   out_valid, out_item         one-cycle strobe, no back-pressure
//   config   cfg_valid, cfg_ready, cfg_data  beat taken when valid & ready
//
// One item is taken per cycle while busy is low; its result is registered at the row
// memory read, then at the evaluation register. After reset a clearing pass zeroes
// all GRID*GRID rows, one row per cycle in every copy, and busy stays high until
// the pass ends. Configuration is always ready.
// The receiver cannot stall the result strobe.
`default_nettype none

module voxel_visible_face_mask #(
  parameter int GRID = vvfm_pkg::GRID_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire vvfm_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  output vvfm_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vvfm_pkg::GRID_SIZE_W-1:0]  cfg_data
);

  import vvfm_pkg::*;

  localparam int DEPTH = GRID * GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam int CLR_W = $clog2(DEPTH + 1);
  localparam int NROW  = 5;

  logic [GRID_SIZE_W-1:0] grid_size_r;
  logic [CLR_W-1:0]       clr_cnt_r;
  logic                   clearing_r;
  logic                   accept;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [GRID-1:0]        wr_data;
  logic [31:0]            row_ext;
  logic                   rd_en;
  logic [COORD_W-1:0]     y, z;
  logic [AW-1:0]          rd_addr [NROW];
  logic [GRID-1:0]        rd_data [NROW];
  cmd_t                   cmd;

  // Row address of (y, z); out-of-range neighbors wrap onto other rows, which the evaluation masks out
  function automatic logic [AW-1:0] row_addr(input logic [COORD_W-1:0] yy,
                                             input logic [COORD_W-1:0] zz);
    logic [11:0] t;
    t = 12'(yy) * 12'(GRID) + 12'(zz);
    return t[AW-1:0];
  endfunction

  assign accept    = start & ~busy;
  assign busy      = clearing_r;
  assign cfg_ready = 1'b1;

  // Hold the grid size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      grid_size_r <= cfg_data;
    end
  end

  // Sweep every row to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
      if (clr_cnt_r == CLR_W'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Write port: clearing pass or a row load
  always_comb begin
    y       = COORD_W'(in_item.cell_y);
    z       = COORD_W'(in_item.cell_z);
    row_ext = 32'(in_item.row_bits);
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r[AW-1:0];
      wr_data = '0;
    end else begin
      wr_en   = accept && (in_item.operation == OP_LOAD)
                && (y < COORD_W'(GRID)) && (z < COORD_W'(GRID));
      wr_addr = row_addr(y, z);
      wr_data = row_ext[GRID-1:0];
    end
  end

  // Read ports: the voxel's row and its four neighbor rows
  always_comb begin
    rd_en      = accept && (in_item.operation == OP_QUERY);
    rd_addr[0] = row_addr(y, z);
    rd_addr[1] = row_addr(y + COORD_W'(1), z);
    rd_addr[2] = row_addr(y - COORD_W'(1), z);
    rd_addr[3] = row_addr(y, z + COORD_W'(1));
    rd_addr[4] = row_addr(y, z - COORD_W'(1));
  end

  for (genvar i = 0; i < NROW; i++) begin : g_row
    vvfm_row_store #(
      .GRID (GRID)
    ) u_store (
      .clk       (clk),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr[i]),
      .rd_data_r (rd_data[i])
    );
  end

  // Command that travels with the reads
  always_comb begin
    cmd.valid     = accept;
    cmd.operation = in_item.operation;
    cmd.cell_x    = in_item.cell_x;
    cmd.cell_y    = in_item.cell_y;
    cmd.cell_z    = in_item.cell_z;
  end

  vvfm_face_eval #(
    .GRID (GRID)
  ) u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .grid_size   (grid_size_r),
    .row_c       (rd_data[0]),
    .row_yp      (rd_data[1]),
    .row_ym      (rd_data[2]),
    .row_zp      (rd_data[3]),
    .row_zm      (rd_data[4]),
    .out_valid_r (out_valid),
    .out_item_r  (out_item)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_voxel_visible_face_mask.sv
// Self-checking testbench for voxel_visible_face_mask: loads occupancy rows, queries
// voxels and checks every face result against a cycle-free predictor of the grid.
// Depends on vvfm_pkg and the voxel_visible_face_mask RTL.
`timescale 1ns / 100ps

module tb_voxel_visible_face_mask;

  localparam int GRID = vvfm_pkg::GRID_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_HOLD = 8;
  localparam int RANDOM_ITEMS = 980;
  localparam int BURST_QUERIES = 120;

  typedef enum logic [1:0] {ST_ITEM, ST_CFG, ST_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t                      kind;
    int unsigned                     idle;
    vvfm_pkg::in_item_t              item;
    logic [vvfm_pkg::GRID_SIZE_W-1:0] gsize;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  vvfm_pkg::in_item_t in_item = '0;
  logic out_valid;
  vvfm_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vvfm_pkg::GRID_SIZE_W-1:0] cfg_data = '0;

  // Stimulus plan and expected face results
  step_t pending_steps[$];
  vvfm_pkg::out_item_t face_expect_q[$];
  int mismatch_count = 0;
  bit burst = 1'b0;
  int plan_size = GRID;

  // Predictor state: occupancy rows indexed [y][z], grid size, vertex counter
  logic [GRID-1:0] occ_rows [GRID][GRID];
  logic [vvfm_pkg::GRID_SIZE_W-1:0] grid_model = vvfm_pkg::GRID_SIZE_RST;
  logic [vvfm_pkg::CNT_W-1:0] vtx_count = '0;

  voxel_visible_face_mask i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cells outside the grid in use read as air
  function automatic bit cell_solid(int x, int y, int z);
    int n;
    n = (grid_model > GRID) ? GRID : int'(grid_model);
    if (x < 0 || y < 0 || z < 0 || x >= n || y >= n || z >= n) return 1'b0;
    return occ_rows[y][z][x];
  endfunction

  // Apply one beat to the predictor and return the face result it causes
  function automatic vvfm_pkg::out_item_t predict_face_result(vvfm_pkg::in_item_t it);
    vvfm_pkg::out_item_t r;
    int x, y, z;
    r = '0;
    x = it.cell_x;
    y = it.cell_y;
    z = it.cell_z;
    if (it.operation == vvfm_pkg::OP_LOAD) begin
      occ_rows[y][z] = it.row_bits[GRID-1:0];
      vtx_count = '0;
    end else begin
      r.first_vertex = vtx_count;
      if (cell_solid(x, y, z)) begin
        r.solid = 1'b1;
        r.face_mask[0] = !cell_solid(x, y + 1, z);
        r.face_mask[1] = !cell_solid(x, y - 1, z);
        r.face_mask[2] = !cell_solid(x + 1, y, z);
        r.face_mask[3] = !cell_solid(x - 1, y, z);
        r.face_mask[4] = !cell_solid(x, y, z + 1);
        r.face_mask[5] = !cell_solid(x, y, z - 1);
        r.face_count = 3'($countones(r.face_mask));
        vtx_count = vtx_count + vvfm_pkg::CNT_W'(vvfm_pkg::VERTS_PER_FACE * r.face_count);
      end
    end
    return r;
  endfunction

  function automatic int unsigned draw_idle();
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic int rand_coord(bit in_grid);
    int n;
    n = (plan_size > GRID) ? GRID : plan_size;
    return (in_grid && n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
  endfunction

  task automatic push_beat(logic op, int x, int y, int z, logic [15:0] bits);
    step_t s;
    s.kind = ST_ITEM;
    s.idle = draw_idle();
    s.item.operation = op;
    s.item.cell_x = 4'(x);
    s.item.cell_y = 4'(y);
    s.item.cell_z = 4'(z);
    s.item.row_bits = bits;
    s.gsize = '0;
    pending_steps.push_back(s);
  endtask

  task automatic push_load(int y, int z, logic [15:0] bits);
    push_beat(vvfm_pkg::OP_LOAD, $urandom_range(0, 15), y, z, bits);
  endtask

  task automatic push_query(int x, int y, int z);
    push_beat(vvfm_pkg::OP_QUERY, x, y, z, 16'($urandom));
  endtask

  // Grid size writes wait in the driver until no face result is outstanding
  task automatic push_step(step_kind_t kind, int gsize);
    step_t s;
    s.kind = kind;
    s.idle = draw_idle();
    s.item = '0;
    s.gsize = vvfm_pkg::GRID_SIZE_W'(gsize);
    if (kind == ST_CFG) plan_size = gsize;
    pending_steps.push_back(s);
  endtask

  // Driver: take finished beats into the predictor, then present the next step
  step_t head;
  int unsigned idle_waited;
  bit item_beat, cfg_beat, present_item, present_cfg, step_go;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      idle_waited = 0;
    end else begin
      item_beat = start && !busy;
      cfg_beat = cfg_valid && cfg_ready;
      if (item_beat) face_expect_q.push_back(predict_face_result(in_item));
      if (cfg_beat) grid_model = cfg_data;
      // hold a beat that has not been taken yet
      if (!((start && !item_beat) || (cfg_valid && !cfg_beat))) begin
        present_item = 1'b0;
        present_cfg = 1'b0;
        step_go = 1'b0;
        if (pending_steps.size() != 0) begin
          head = pending_steps[0];
          if (idle_waited < head.idle) begin
            idle_waited++;
          end else begin
            case (head.kind)
              ST_ITEM: begin
                in_item <= head.item;
                present_item = 1'b1;
                step_go = 1'b1;
              end
              ST_CFG: begin
                if (face_expect_q.size() == 0) begin
                  cfg_data <= head.gsize;
                  present_cfg = 1'b1;
                  step_go = 1'b1;
                end
              end
              ST_DRAIN: begin
                step_go = (face_expect_q.size() == 0);
              end
            endcase
          end
          if (step_go) begin
            void'(pending_steps.pop_front());
            idle_waited = 0;
          end
        end
        start <= present_item;
        cfg_valid <= present_cfg;
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expectation
  vvfm_pkg::out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (face_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected face result solid %0b mask %02h count %0d first %0d",
                   $time, out_item.solid, out_item.face_mask, out_item.face_count,
                   out_item.first_vertex);
      end else begin
        want = face_expect_q.pop_front();
        if (out_valid !== 1'b1 ||
            out_item.solid !== want.solid ||
            out_item.face_mask !== want.face_mask ||
            out_item.face_count !== want.face_count ||
            out_item.first_vertex !== want.first_vertex) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: face result mismatch, expected solid %0b mask %02h count %0d ",
                      "first %0d, got solid %0b mask %02h count %0d first %0d"},
                     $time, want.solid, want.face_mask, want.face_count, want.first_vertex,
                     out_item.solid, out_item.face_mask, out_item.face_count,
                     out_item.first_vertex);
        end
      end
    end
  end

  // Watchdog: count cycles without any beat on any channel
  int stall_cycles = 0;

  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n_items, n_loads, n_queries;
    logic [15:0] bits;
    foreach (occ_rows[y, z]) occ_rows[y][z] = '0;

    // Directed: full row at the grid edge, lone corner voxel, enclosed voxel, air
    push_load(0, 0, 16'hFFFF);
    push_query(0, 0, 0);
    push_query(15, 0, 0);
    push_load(15, 15, 16'h8000);
    push_query(15, 15, 15);
    push_load(5, 5, 16'h0070);
    push_load(4, 5, 16'h0020);
    push_load(6, 5, 16'h0020);
    push_load(5, 4, 16'h0020);
    push_load(5, 6, 16'h0020);
    push_query(5, 5, 5);
    push_query(5, 5, 4);
    push_query(3, 9, 2);
    push_load(0, 0, 16'h0001);
    push_step(ST_DRAIN, 0);
    // Grid size zero: every query answers air
    push_step(ST_CFG, 0);
    push_query(0, 0, 0);
    // One-voxel grid: all six faces visible
    push_step(ST_CFG, 1);
    push_query(0, 0, 0);
    push_query(1, 0, 0);
    // Oversized grid saturates to the full grid
    push_step(ST_CFG, 31);
    push_query(0, 0, 0);
    // Row stored outside the smaller grid stays hidden until the grid grows
    push_step(ST_CFG, 8);
    push_load(12, 3, 16'hFFFF);
    push_query(7, 12, 3);
    push_load(7, 7, 16'hFF80);
    push_query(7, 7, 7);
    push_step(ST_CFG, 16);
    push_query(8, 12, 3);

    // Back-to-back six-face queries on an isolated voxel
    burst = 1'b1;
    push_load(10, 10, 16'h0400);
    repeat (BURST_QUERIES) push_query(10, 10, 10);
    burst = 1'b0;

    // Random: phases of row loads followed by queries, mostly inside the grid in use
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) push_step(ST_CFG, $urandom_range(0, 31));
      if ($urandom_range(0, 4) == 0) push_step(ST_DRAIN, 0);
      burst = ($urandom_range(0, 3) == 0);
      n_loads = $urandom_range(1, 10);
      repeat (n_loads) begin
        case ($urandom_range(0, 3))
          0: bits = 16'($urandom) & 16'($urandom);
          1: bits = 16'($urandom) | 16'($urandom);
          2: bits = 16'hFFFF ^ (16'h1 << $urandom_range(0, 15));
          default: bits = 16'($urandom);
        endcase
        push_load(rand_coord($urandom_range(0, 7) != 0),
                  rand_coord($urandom_range(0, 7) != 0), bits);
      end
      n_queries = $urandom_range(5, 40);
      repeat (n_queries)
        push_query(rand_coord($urandom_range(0, 7) != 0),
                   rand_coord($urandom_range(0, 7) != 0),
                   rand_coord($urandom_range(0, 7) != 0));
      n_items += n_loads + n_queries;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the plan to run out and every face result to arrive
    while (pending_steps.size() != 0 || start || cfg_valid || face_expect_q.size() != 0)
      @(posedge clk);
    repeat (END_HOLD) @(posedge clk);
    if (mismatch_count == 0 && face_expect_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
